// ===== design/lzw_variable_width_encoder_assert.svh =====
// Assertion macros for the LZW variable width encoder.
`ifndef LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LZW_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lzw encoder assertion failed");

// Next-cycle implication, disabled during reset.
`define LZW_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lzw encoder assertion failed");

`endif

// ===== design/lzwve_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwve_pkg
// Shared constants, types and helpers of the LZW variable width encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwve_pkg;

   localparam logic [3:0]  MIN_WIDTH  = 4'd9;
   localparam logic [3:0]  MAX_WIDTH  = 4'd12;
   localparam logic [12:0] FIRST_FREE = 13'd256;
   localparam logic [12:0] CODE_LIMIT = 13'd4096;
   localparam int          DICT_DEPTH = 3840;
   localparam int          SLOT_DEPTH = 8192;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } item_type;

   typedef struct packed {
      logic [11:0] prefix;
      logic [7:0]  suffix;
      logic [12:0] slot;
   } dict_entry_type;

   // All-ones word of the given width, right aligned in 12 bits.
   function automatic logic [11:0] all_ones(input logic [3:0] width);
      logic [12:0] full;
      full = (13'd1 << width) - 13'd1;
      return full[11:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/lzwve_if.sv =====
// ----------------------------------------------------------------------------
// lzwve_if
// Valid/ready channels carrying input bytes and output code beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwve_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;
   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lzwve_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] code_word;
   logic [3:0]  code_width;
   logic        is_escape;
   logic        last_of_item;
   logic        stream_done;
   modport source (output valid, output code_word, output code_width, output is_escape,
                   output last_of_item, output stream_done, input ready);
   modport sink   (input valid, input code_word, input code_width, input is_escape,
                   input last_of_item, input stream_done, output ready);
endinterface

`default_nettype wire

// ===== design/lzwve_front.sv =====
// ----------------------------------------------------------------------------
// lzwve_front
// Accepts input beats into a two-entry queue that feeds the encoding core.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwve_front (
   input  wire logic               clock,
   input  wire logic               reset,
   lzwve_req_if.sink               req_chan,
   output lzwve_pkg::item_type     q_item,
   output logic                    q_valid,
   input  wire logic               q_pop
);

   lzwve_pkg::item_type entry_ff [0:1];
   lzwve_pkg::item_type entry_in [0:1];
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_item         = entry_ff[0];

   always_comb begin
      lzwve_pkg::item_type incoming;
      incoming.data_byte     = req_chan.data_byte;
      incoming.end_of_stream = req_chan.end_of_stream;
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      count_in    = count_ff;
      if (q_pop && q_valid) begin
         entry_in[0] = entry_ff[1];
         count_in    = count_in - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            entry_in[0] = incoming;
         end else begin
            entry_in[1] = incoming;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lzwve_core.sv =====
// ----------------------------------------------------------------------------
// lzwve_core
// Dictionary probe, insert and code emission for one queued byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwve_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lzwve_pkg::item_type q_item,
   input  wire logic               q_valid,
   output logic                    q_pop,
   lzwve_rsp_if.source             rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SLOT = 6'b000010,
      ST_DICT = 6'b000100,
      ST_CMP  = 6'b001000,
      ST_EMIT = 6'b010000,
      ST_EOS  = 6'b100000
   } state_type;

   // Hash slots hold a code; the code-indexed dictionary points back to its slot,
   // so a slot is live only while that back pointer still matches.
   logic [11:0]               slot_mem_ff [0:lzwve_pkg::SLOT_DEPTH-1];
   lzwve_pkg::dict_entry_type dict_mem_ff [0:lzwve_pkg::DICT_DEPTH-1];

   state_type   state_ff, state_in;
   logic [11:0] prefix_ff, prefix_in;
   logic        have_ff, have_in;
   logic [12:0] nfc_ff, nfc_in;
   logic [3:0]  width_ff, width_in;
   logic [7:0]  byte_ff, byte_in;
   logic        eos_ff, eos_in;
   logic [12:0] slot_ff, slot_in;
   logic [11:0] slot_q_ff;
   lzwve_pkg::dict_entry_type dict_q_ff;

   logic        rv_ff, rv_in;
   logic [11:0] rcode_ff, rcode_in;
   logic [3:0]  rwidth_ff, rwidth_in;
   logic        resc_ff, resc_in, rlast_ff, rlast_in, rdone_ff, rdone_in;

   logic        wr_en;
   logic [11:0] dict_wr_addr, dict_rd_addr;
   logic        out_free, live, match, esc;
   lzwve_pkg::dict_entry_type wr_entry;

   assign out_free      = !rv_ff || rsp_chan.ready;
   assign dict_rd_addr  = slot_q_ff - 12'd256;
   assign dict_wr_addr  = nfc_ff[11:0] - 12'd256;
   assign live          = (slot_q_ff >= 12'd256) && ({1'b0, slot_q_ff} < nfc_ff)
                          && (dict_q_ff.slot == slot_ff);
   assign match         = live && (dict_q_ff.prefix == prefix_ff)
                          && (dict_q_ff.suffix == byte_ff);
   assign esc           = (width_ff != lzwve_pkg::MAX_WIDTH)
                          && (prefix_ff >= lzwve_pkg::all_ones(width_ff));
   assign wr_entry.prefix = prefix_ff;
   assign wr_entry.suffix = byte_ff;
   assign wr_entry.slot   = slot_ff;

   assign rsp_chan.valid        = rv_ff;
   assign rsp_chan.code_word    = rcode_ff;
   assign rsp_chan.code_width   = rwidth_ff;
   assign rsp_chan.is_escape    = resc_ff;
   assign rsp_chan.last_of_item = rlast_ff;
   assign rsp_chan.stream_done  = rdone_ff;

   always_comb begin
      state_in  = state_ff;
      prefix_in = prefix_ff;
      have_in   = have_ff;
      nfc_in    = nfc_ff;
      width_in  = width_ff;
      byte_in   = byte_ff;
      eos_in    = eos_ff;
      slot_in   = slot_ff;
      rv_in     = rv_ff && !rsp_chan.ready;
      rcode_in  = rcode_ff;
      rwidth_in = rwidth_ff;
      resc_in   = resc_ff;
      rlast_in  = rlast_ff;
      rdone_in  = rdone_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               byte_in = q_item.data_byte;
               eos_in  = q_item.end_of_stream;
               if (!have_ff) begin
                  prefix_in = {4'd0, q_item.data_byte};
                  have_in   = 1'b1;
                  state_in  = q_item.end_of_stream ? ST_EOS : ST_IDLE;
               end else begin
                  slot_in  = {1'b0, prefix_ff} ^ {q_item.data_byte, 5'd0};
                  state_in = ST_SLOT;
               end
            end
         end
         ST_SLOT: state_in = ST_DICT;
         ST_DICT: state_in = ST_CMP;
         ST_CMP: begin
            if (match) begin
               prefix_in = slot_q_ff;
               state_in  = eos_ff ? ST_EOS : ST_IDLE;
            end else if (live) begin
               slot_in  = slot_ff + 13'd1;
               state_in = ST_SLOT;
            end else begin
               if (nfc_ff < lzwve_pkg::CODE_LIMIT) begin
                  wr_en  = 1'b1;
                  nfc_in = nfc_ff + 13'd1;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rv_in   = 1'b1;
               rdone_in = 1'b0;
               if (esc) begin
                  rcode_in  = lzwve_pkg::all_ones(width_ff);
                  rwidth_in = width_ff;
                  resc_in   = 1'b1;
                  rlast_in  = 1'b0;
                  width_in  = width_ff + 4'd1;
               end else begin
                  rcode_in  = prefix_ff;
                  rwidth_in = width_ff;
                  resc_in   = 1'b0;
                  rlast_in  = !eos_ff;
                  prefix_in = {4'd0, byte_ff};
                  state_in  = eos_ff ? ST_EOS : ST_IDLE;
               end
            end
         end
         ST_EOS: begin
            if (out_free) begin
               rv_in     = 1'b1;
               rcode_in  = prefix_ff;
               rwidth_in = width_ff;
               resc_in   = 1'b0;
               rlast_in  = 1'b1;
               rdone_in  = 1'b1;
               prefix_in = 12'd0;
               have_in   = 1'b0;
               nfc_in    = lzwve_pkg::FIRST_FREE;
               width_in  = lzwve_pkg::MIN_WIDTH;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_q_ff <= slot_mem_ff[slot_ff];
      dict_q_ff <= dict_mem_ff[dict_rd_addr];
      if (wr_en) begin
         slot_mem_ff[slot_ff]      <= nfc_ff[11:0];
         dict_mem_ff[dict_wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      eos_ff    <= eos_in;
      slot_ff   <= slot_in;
      rcode_ff  <= rcode_in;
      rwidth_ff <= rwidth_in;
      resc_ff   <= resc_in;
      rlast_ff  <= rlast_in;
      rdone_ff  <= rdone_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         prefix_ff <= 12'd0;
         have_ff   <= 1'b0;
         nfc_ff    <= lzwve_pkg::FIRST_FREE;
         width_ff  <= lzwve_pkg::MIN_WIDTH;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prefix_ff <= prefix_in;
         have_ff   <= have_in;
         nfc_ff    <= nfc_in;
         width_ff  <= width_in;
         rv_ff     <= rv_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lzw_variable_width_encoder.sv =====
// ----------------------------------------------------------------------------
// lzw_variable_width_encoder
// LZW encoder with variable code width, one input byte per beat.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on req_chan, each with an end-of-stream flag. Codes leave
// on rsp_chan as right-aligned words with their width; an escape beat carries
// the all-ones word of the old width and announces a width one bit wider.
// The last beat caused by a byte has last_of_item set; the final code of a
// stream has stream_done set, after which a fresh stream begins.
// Timing: a two-entry queue takes bytes while the core is busy. The core takes
// a byte in its idle state, then runs each hash probe through the slot read,
// dictionary read and compare states, and emits each beat from the emit or
// end-of-stream state once the output register is free. Each collision in the
// hash table adds another probe, and this probe loop sets the throughput.
// Reset: synchronous, active high; it empties the queue, clears the prefix and
// restores width 9 and next code 256. The dictionary needs no clearing pass,
// since slots are checked against back pointers and the next free code.
// Stalls: a beat on rsp_chan holds until taken; meanwhile the core waits once it
// has another beat to emit, and the queue keeps accepting bytes until it holds two.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_variable_width_encoder (
   input  wire logic   clock,
   input  wire logic   reset,
   lzwve_req_if.sink   req_chan,
   lzwve_rsp_if.source rsp_chan
);

   lzwve_pkg::item_type q_item;
   logic                q_valid;
   logic                q_pop;

   // Front end: accepts bytes and buffers them.
   lzwve_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   // Back end: dictionary search, insertion and the output register.
   lzwve_core u_core (
      .clock    (clock),
      .reset    (reset),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== design/lzwve_checker.sv =====
// ----------------------------------------------------------------------------
// lzwve_checker
// Port-level checks on the encoder's output beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lzw_variable_width_encoder_assert.svh"

module lzwve_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [11:0] code_word,
   input wire logic [3:0]  code_width,
   input wire logic        is_escape,
   input wire logic        last_of_item,
   input wire logic        stream_done
);

   `LZW_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(code_word))
   `LZW_ASSERT_IMP(a_escape, clock, reset, rsp_valid && is_escape, (code_width != 4'd12) && (code_word == lzwve_pkg::all_ones(code_width)))
   `LZW_ASSERT_IMP(a_done_last, clock, reset, rsp_valid && stream_done, last_of_item && !is_escape)
   `LZW_ASSERT_IMP(a_width, clock, reset, rsp_valid, (code_width >= 4'd9) && (code_width <= 4'd12))

endmodule

bind lzw_variable_width_encoder lzwve_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .code_word    (rsp_chan.code_word),
   .code_width   (rsp_chan.code_width),
   .is_escape    (rsp_chan.is_escape),
   .last_of_item (rsp_chan.last_of_item),
   .stream_done  (rsp_chan.stream_done)
);

`default_nettype wire
